/* rtl/core/ihex_pkg.sv */
package ihex_pkg;

  // Record geometry
  localparam int REC_BYTES  = 16;
  localparam int LEN_W      = 8;
  localparam int COUNT_W    = 17;
  localparam int ADDR_W     = 16;
  localparam int CHAR_W     = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd1;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Sum of the fixed bytes 02 00 00 04 of the address record
  localparam logic [7:0] ELA_SUM_BASE = 8'h06;

  // Characters used by the record text
  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_TWO   = 7'h32;
  localparam logic [CHAR_W-1:0] CH_FOUR  = 7'h34;
  localparam logic [CHAR_W-1:0] CH_F     = 7'h46;

  // Segment of the text for one byte
  typedef enum logic [2:0] {
    PH_ELA,
    PH_HDR,
    PH_DAT,
    PH_CLS,
    PH_END
  } ihex_phase_t;

  // Everything the back end needs to print the text of one byte
  typedef struct packed {
    logic              ela;
    logic [ADDR_W-1:0] start_addr;
    logic [7:0]        ela_ck;
    logic              open;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              close;
    logic [7:0]        rec_ck;
    logic              last;
  } ihex_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ihex_fifo_st_t;

  // Upper-case hex digit for one nibble
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {3'd0, nib};
    end else begin
      c = 7'h37 + {3'd0, nib};
    end
    return c;
  endfunction

endpackage

/* rtl/core/ihex_front.sv */
module ihex_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ihex_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                           in_fire,
  input  logic [7:0]                     in_data_byte,
  output ihex_pkg::ihex_cmd_t            cmd
);

  logic [ihex_pkg::COUNT_W-1:0] byte_count_r;
  logic [ihex_pkg::ADDR_W-1:0]  start_address_r;
  logic [ihex_pkg::COUNT_W-1:0] byte_offset_r, byte_offset_nxt;
  logic [7:0]                   running_sum_r, running_sum_nxt;
  logic [ihex_pkg::LEN_W-1:0]   record_length_r, record_length_nxt;
  logic [ihex_pkg::LEN_W-1:0]   rec_fill_r, rec_fill_nxt;

  logic [ihex_pkg::COUNT_W-1:0] cnt;
  logic [ihex_pkg::COUNT_W-1:0] rem;
  logic [ihex_pkg::COUNT_W:0]   off_inc;
  logic [ihex_pkg::LEN_W-1:0]   len;
  logic [ihex_pkg::LEN_W-1:0]   reclen_eff;
  logic [ihex_pkg::LEN_W:0]     fill_inc;
  logic [7:0]                   base_sum;
  logic [7:0]                   sum_new;
  logic                         open_rec;
  logic                         last;
  logic                         close;

  // Classify the incoming byte against the conversion state
  always_comb begin
    cnt      = (byte_count_r == '0) ? ihex_pkg::COUNT_W'(1) : byte_count_r;
    rem      = (cnt > byte_offset_r) ? (cnt - byte_offset_r) : ihex_pkg::COUNT_W'(1);
    len      = (rem < ihex_pkg::COUNT_W'(ihex_pkg::REC_BYTES)) ?
               rem[ihex_pkg::LEN_W-1:0] : ihex_pkg::LEN_W'(ihex_pkg::REC_BYTES);
    open_rec = (record_length_r == '0);
    off_inc  = {1'b0, byte_offset_r} + (ihex_pkg::COUNT_W+1)'(1);
    last     = (off_inc >= {1'b0, cnt});
    base_sum = len + byte_offset_r[15:8] + byte_offset_r[7:0];
    sum_new  = (open_rec ? base_sum : running_sum_r) + in_data_byte;
    reclen_eff = open_rec ? len : record_length_r;
    fill_inc = {1'b0, rec_fill_r} + (ihex_pkg::LEN_W+1)'(1);
    close    = (fill_inc >= {1'b0, reclen_eff}) || last;

    cmd.ela        = (byte_offset_r == '0);
    cmd.start_addr = start_address_r;
    cmd.ela_ck     = 8'd0 - (ihex_pkg::ELA_SUM_BASE + start_address_r[15:8]
                             + start_address_r[7:0]);
    cmd.open       = open_rec;
    cmd.len        = len;
    cmd.addr       = byte_offset_r[ihex_pkg::ADDR_W-1:0];
    cmd.data       = in_data_byte;
    cmd.close      = close;
    cmd.rec_ck     = 8'd0 - sum_new;
    cmd.last       = last;
  end

  // Advance the conversion state by one byte
  always_comb begin
    byte_offset_nxt   = last ? '0 : off_inc[ihex_pkg::COUNT_W-1:0];
    running_sum_nxt   = sum_new;
    record_length_nxt = close ? '0 : reclen_eff;
    rec_fill_nxt      = close ? '0 : fill_inc[ihex_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= ihex_pkg::COUNT_W'(1);
      start_address_r <= '0;
      byte_offset_r   <= '0;
      running_sum_r   <= '0;
      record_length_r <= '0;
      rec_fill_r      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ihex_pkg::REG_BYTE_COUNT:    byte_count_r    <= cfg_data;
          ihex_pkg::REG_START_ADDRESS: start_address_r <= cfg_data[ihex_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        byte_offset_r   <= byte_offset_nxt;
        running_sum_r   <= running_sum_nxt;
        record_length_r <= record_length_nxt;
        rec_fill_r      <= rec_fill_nxt;
      end
    end
  end

endmodule

/* rtl/core/ihex_cmd_fifo.sv */
module ihex_cmd_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ihex_pkg::ihex_cmd_t    push_cmd,
  input  logic                   pop,
  output ihex_pkg::ihex_cmd_t    head,
  output ihex_pkg::ihex_fifo_st_t st
);

  ihex_pkg::ihex_cmd_t             mem [ihex_pkg::FIFO_DEPTH];
  logic [ihex_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ihex_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ihex_pkg::FIFO_CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    st.full    = (cnt_r == ihex_pkg::FIFO_CW'(ihex_pkg::FIFO_DEPTH));
    st.empty   = (cnt_r == '0);
    head       = mem[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r + ihex_pkg::FIFO_AW'(1);
    rd_ptr_nxt = rd_ptr_r + ihex_pkg::FIFO_AW'(1);
    cnt_nxt    = cnt_r + ihex_pkg::FIFO_CW'(push) - ihex_pkg::FIFO_CW'(pop);
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/ihex_back.sv */
module ihex_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ihex_pkg::ihex_cmd_t           head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ihex_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_run_last
);

  logic                        busy_r, busy_nxt;
  ihex_pkg::ihex_phase_t       phase_r, phase_nxt;
  logic [4:0]                  idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ihex_pkg::CHAR_W-1:0] out_char_r;
  logic                        out_last_r;

  ihex_pkg::ihex_phase_t       eff_phase;
  ihex_pkg::ihex_phase_t       next_phase;
  logic [4:0]                  eff_idx;
  logic [4:0]                  seg_last;
  logic                        has_next;
  logic                        at_end;
  logic                        load;
  logic                        fire;
  logic                        done;
  logic [ihex_pkg::CHAR_W-1:0] ch;

  // Pick up the segment in progress, or the first one of a fresh command
  always_comb begin
    if (busy_r) begin
      eff_phase = phase_r;
      eff_idx   = idx_r;
    end else begin
      eff_idx = '0;
      if (head.ela) begin
        eff_phase = ihex_pkg::PH_ELA;
      end else if (head.open) begin
        eff_phase = ihex_pkg::PH_HDR;
      end else begin
        eff_phase = ihex_pkg::PH_DAT;
      end
    end
  end

  // Segment length and successor
  always_comb begin
    has_next   = 1'b0;
    next_phase = ihex_pkg::PH_DAT;
    seg_last   = 5'd1;
    case (eff_phase)
      ihex_pkg::PH_ELA: begin
        seg_last   = 5'd16;
        has_next   = 1'b1;
        next_phase = head.open ? ihex_pkg::PH_HDR : ihex_pkg::PH_DAT;
      end
      ihex_pkg::PH_HDR: begin
        seg_last   = 5'd8;
        has_next   = 1'b1;
        next_phase = ihex_pkg::PH_DAT;
      end
      ihex_pkg::PH_DAT: begin
        seg_last   = 5'd1;
        has_next   = head.close || head.last;
        next_phase = head.close ? ihex_pkg::PH_CLS : ihex_pkg::PH_END;
      end
      ihex_pkg::PH_CLS: begin
        seg_last   = 5'd3;
        has_next   = head.last;
        next_phase = ihex_pkg::PH_END;
      end
      ihex_pkg::PH_END: begin
        seg_last   = 5'd10;
        has_next   = 1'b0;
      end
      default: ;
    endcase
    at_end = (eff_idx == seg_last);
    done   = at_end && !has_next;
  end

  // Next state of the character sequencer
  always_comb begin
    load          = !out_valid_r || out_ready;
    fire          = head_valid && load;
    pop           = fire && done;
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    out_valid_nxt = load ? fire : out_valid_r;
    if (fire) begin
      if (!at_end) begin
        busy_nxt  = 1'b1;
        phase_nxt = eff_phase;
        idx_nxt   = eff_idx + 5'd1;
      end else if (has_next) begin
        busy_nxt  = 1'b1;
        phase_nxt = next_phase;
        idx_nxt   = '0;
      end else begin
        busy_nxt  = 1'b0;
        idx_nxt   = '0;
      end
    end
  end

  // Character for the current position
  always_comb begin
    ch = ihex_pkg::CH_ZERO;
    case (eff_phase)
      ihex_pkg::PH_ELA: begin
        case (eff_idx)
          5'd0:  ch = ihex_pkg::CH_COLON;
          5'd2:  ch = ihex_pkg::CH_TWO;
          5'd8:  ch = ihex_pkg::CH_FOUR;
          5'd9:  ch = ihex_pkg::hex_char(head.start_addr[15:12]);
          5'd10: ch = ihex_pkg::hex_char(head.start_addr[11:8]);
          5'd11: ch = ihex_pkg::hex_char(head.start_addr[7:4]);
          5'd12: ch = ihex_pkg::hex_char(head.start_addr[3:0]);
          5'd13: ch = ihex_pkg::hex_char(head.ela_ck[7:4]);
          5'd14: ch = ihex_pkg::hex_char(head.ela_ck[3:0]);
          5'd15: ch = ihex_pkg::CH_CR;
          5'd16: ch = ihex_pkg::CH_LF;
          default: ch = ihex_pkg::CH_ZERO;
        endcase
      end
      ihex_pkg::PH_HDR: begin
        case (eff_idx)
          5'd0:  ch = ihex_pkg::CH_COLON;
          5'd1:  ch = ihex_pkg::hex_char(head.len[7:4]);
          5'd2:  ch = ihex_pkg::hex_char(head.len[3:0]);
          5'd3:  ch = ihex_pkg::hex_char(head.addr[15:12]);
          5'd4:  ch = ihex_pkg::hex_char(head.addr[11:8]);
          5'd5:  ch = ihex_pkg::hex_char(head.addr[7:4]);
          5'd6:  ch = ihex_pkg::hex_char(head.addr[3:0]);
          default: ch = ihex_pkg::CH_ZERO;
        endcase
      end
      ihex_pkg::PH_DAT: begin
        ch = (eff_idx == '0) ? ihex_pkg::hex_char(head.data[7:4]) :
                               ihex_pkg::hex_char(head.data[3:0]);
      end
      ihex_pkg::PH_CLS: begin
        case (eff_idx)
          5'd0:  ch = ihex_pkg::hex_char(head.rec_ck[7:4]);
          5'd1:  ch = ihex_pkg::hex_char(head.rec_ck[3:0]);
          5'd2:  ch = ihex_pkg::CH_CR;
          default: ch = ihex_pkg::CH_LF;
        endcase
      end
      ihex_pkg::PH_END: begin
        case (eff_idx)
          5'd0:  ch = ihex_pkg::CH_COLON;
          5'd8:  ch = ihex_pkg::CH_ONE;
          5'd9:  ch = ihex_pkg::CH_F;
          5'd10: ch = ihex_pkg::CH_F;
          default: ch = ihex_pkg::CH_ZERO;
        endcase
      end
      default: ch = ihex_pkg::CH_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= ihex_pkg::PH_DAT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register: load on a free slot or a transfer
  always_ff @(posedge clk) begin
    if (fire) begin
      out_char_r <= ch;
      out_last_r <= done;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_run_last = out_last_r;

endmodule

/* rtl/core/intel_hex_record_encoder_unit.sv */
// Intel HEX record encoder: one image byte in, its HEX text out, one character a cycle unless out_ready stalls it.
// When the queue is empty and the sequencer is idle, the command of a byte is registered
// in the command queue, and its first character then in the output register.
// The output register gives one character per cycle while out_ready is high; a byte
// yields 2 to 43 characters (2 for a plain data byte, about 2.8 on average with 16-byte records).
// A four-entry command queue lets input bytes run ahead of the character sequencer.
// Reset (rst_n low, synchronous): byte_count 1, start_address 0, no conversion open.
module intel_hex_record_encoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ihex_pkg::CHAR_W-1:0]    out_char,
  output logic                           out_run_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ihex_pkg::COUNT_W-1:0]   cfg_data
);

  ihex_pkg::ihex_cmd_t     front_cmd;
  ihex_pkg::ihex_cmd_t     head_cmd;
  ihex_pkg::ihex_fifo_st_t fifo_st;
  logic                    in_fire;
  logic                    cmd_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !fifo_st.full;
  assign in_fire   = in_valid && in_ready;

  ihex_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_data_byte (in_data_byte),
    .cmd          (front_cmd)
  );

  ihex_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .push_cmd (front_cmd),
    .pop      (cmd_pop),
    .head     (head_cmd),
    .st       (fifo_st)
  );

  ihex_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head_cmd),
    .head_valid   (!fifo_st.empty),
    .pop          (cmd_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

  // A command leaves the queue only when one is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !fifo_st.empty)
    else $error("command popped from empty queue");

  // Retiring a command puts its final character, flagged, into the output register
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (out_valid && out_run_last))
    else $error("retired command without flagged last character");

  // Output is empty right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* bench/intel_hex_record_encoder_unit_tb.sv */
module intel_hex_record_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned RANDOM_BYTES  = 480;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_PHASE    = 4;
  localparam int unsigned MAX_GAP       = 12;

  // Register slots beyond the two real ones; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Upper-case digit lookup, digit n sits in byte n counted from the left
  localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

  // Fixed texts for single-byte conversions at the register defaults and extremes
  localparam string TEXT_ZERO_AT_RESET =
    ":020000040000FA\015\012:0100000000FF\015\012:00000001FF";
  localparam string TEXT_ONES_AT_RESET =
    ":020000040000FA\015\012:01000000FF00\015\012:00000001FF";
  localparam string TEXT_TOP_ADDRESS =
    ":02000004FFFFFC\015\012:01000000A55A\015\012:00000001FF";

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [COUNT_W-1:0]   val;
  } stim_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } hex_char_t;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_run_last;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [COUNT_W-1:0]   cfg_data     = '0;

  // Shadow of the encoder: registers and conversion progress
  logic [COUNT_W-1:0]   count_reg;
  logic [ADDR_W-1:0]    base_addr;
  logic [COUNT_W-1:0]   img_pos;
  logic [7:0]           rec_sum;
  logic [7:0]           rec_len;
  logic [7:0]           rec_fill;

  logic [CHAR_W-1:0]    line_chars[$];
  hex_char_t            chars_due[$];
  stim_row_t            stim_rows[$];
  string                stim_text[$];

  int unsigned          fail_count   = 0;
  int unsigned          cycle_count  = 0;
  logic                 tx_burst     = 1'b0;
  logic                 rx_burst     = 1'b0;
  logic                 hold_off_req = 1'b0;

  intel_hex_record_encoder_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still due", cycle_count,
               chars_due.size());
      $display("intel_hex_record_encoder_unit_tb failed");
      $finish;
    end
  end

  function automatic void put_char(input logic [CHAR_W-1:0] c);
    line_chars.push_back(c);
  endfunction

  function automatic void put_hex2(input logic [7:0] v);
    put_char(HEX_DIGITS[8*(15 - v[7:4]) +: CHAR_W]);
    put_char(HEX_DIGITS[8*(15 - v[3:0]) +: CHAR_W]);
  endfunction

  function automatic void put_text(input string s);
    byte c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      put_char(c[CHAR_W-1:0]);
    end
  endfunction

  function automatic void put_line_end(input logic [7:0] sum);
    put_hex2(8'h00 - sum);
    put_char(CH_CR);
    put_char(CH_LF);
  endfunction

  // Work out the HEX text that one image byte produces and advance the shadow state
  function automatic void encode_byte(input logic [7:0] d);
    logic [COUNT_W-1:0] eff_count;
    logic [COUNT_W-1:0] left;
    logic [7:0]         len;
    logic [ADDR_W-1:0]  addr;
    logic               done;
    line_chars.delete();
    eff_count = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    // Address record opens every conversion
    if (img_pos == '0) begin
      put_text(":02000004");
      put_hex2(base_addr[15:8]);
      put_hex2(base_addr[7:0]);
      put_line_end(ELA_SUM_BASE + base_addr[15:8] + base_addr[7:0]);
    end
    // Open a data record sized from the count as it stands now
    if (rec_len == '0) begin
      left     = (eff_count > img_pos) ? eff_count - img_pos : COUNT_W'(1);
      len      = (left < COUNT_W'(REC_BYTES)) ? left[7:0] : 8'(REC_BYTES);
      addr     = img_pos[ADDR_W-1:0];
      rec_len  = len;
      rec_fill = '0;
      put_char(CH_COLON);
      put_hex2(len);
      put_hex2(addr[15:8]);
      put_hex2(addr[7:0]);
      put_text("00");
      rec_sum  = len + addr[15:8] + addr[7:0];
    end
    put_hex2(d);
    rec_sum  = rec_sum + d;
    rec_fill = rec_fill + 8'd1;
    img_pos  = img_pos + COUNT_W'(1);
    done     = (img_pos >= eff_count);
    // Close the record when full, or short when the conversion ends
    if (rec_fill >= rec_len || done) begin
      put_line_end(rec_sum);
      rec_len  = '0;
      rec_fill = '0;
    end
    if (done) begin
      put_text(":00000001FF");
      img_pos = '0;
    end
  endfunction

  // Queue the characters due for one byte; a fixed text overrides the shadow's output
  function automatic void book_results(input string fixed_text);
    hex_char_t e;
    if (fixed_text.len() != 0) begin
      line_chars.delete();
      put_text(fixed_text);
    end
    foreach (line_chars[i]) begin
      e.ch   = line_chars[i];
      e.last = (i == line_chars.size() - 1);
      chars_due.push_back(e);
    end
  endfunction

  function automatic int unsigned draw_gap();
    return tx_burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input string fixed_text);
    stim_row_t row;
    row.kind = ROW_BYTE;
    row.idx  = '0;
    row.val  = {{(COUNT_W-8){1'b0}}, b};
    stim_rows.push_back(row);
    stim_text.push_back(fixed_text);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COUNT_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val;
    stim_rows.push_back(row);
    stim_text.push_back("");
  endfunction

  // Offer one byte; book its text at the transfer
  task automatic send_byte(input logic [7:0] b, input string fixed_text,
                           input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_byte(b);
    book_results(fixed_text);
  endtask

  // Write one register; valid is left high so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BYTE_COUNT:    count_reg = val;
      REG_START_ADDRESS: base_addr = val[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  // Hold the input until every due character is out and the block has gone quiet
  task automatic quiesce();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random back-pressure, one long hold-off on request
  initial begin : take_chars
    int unsigned stall;
    hex_char_t   want;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      // Compare the transfer against the oldest due character
      if (chars_due.size() == 0) begin
        fail_count++;
        $display("%0t: char %h last %b arrived with nothing due", $time, out_char,
                 out_run_last);
      end else begin
        want = chars_due.pop_front();
        if (out_char !== want.ch) begin
          fail_count++;
          $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
        end
        if (out_run_last !== want.last) begin
          fail_count++;
          $display("%0t: out_run_last expected %b got %b", $time, want.last,
                   out_run_last);
        end
      end
    end
  end

  initial begin : stimulus
    logic               cfg_held;
    logic               wrote;
    logic [COUNT_W-1:0] new_count;
    logic [COUNT_W-1:0] eff_count;
    logic [COUNT_W-1:0] left;
    int unsigned        batch;
    int unsigned        random_sent;
    int unsigned        phase;

    count_reg = COUNT_W'(1);
    base_addr = '0;
    img_pos   = '0;
    rec_sum   = '0;
    rec_len   = '0;
    rec_fill  = '0;

    // Register defaults, then the extremes of both registers
    add_byte(8'h00, TEXT_ZERO_AT_RESET);
    add_byte(8'hFF, TEXT_ONES_AT_RESET);
    add_cfg(REG_BYTE_COUNT, 17'd0);
    add_cfg(REG_START_ADDRESS, 17'h0FFFF);
    add_cfg(REG_SPARE_A, 17'h1ABCD);
    add_cfg(REG_SPARE_B, 17'h1FFFF);
    add_byte(8'hA5, TEXT_TOP_ADDRESS);
    // Full record then a second one cut short by lowering the count
    add_cfg(REG_BYTE_COUNT, 17'd20);
    add_cfg(REG_START_ADDRESS, 17'h01234);
    for (int i = 0; i < 8; i++) begin
      add_byte(8'h01 << i, "");
      add_byte(~(8'h01 << i), "");
    end
    add_byte(8'h5A, "");
    add_cfg(REG_BYTE_COUNT, 17'd18);
    add_byte(8'hC3, "");
    // Count raised while a record is open, then dropped below the offset
    add_cfg(REG_BYTE_COUNT, 17'd2);
    add_byte(8'h11, "");
    add_cfg(REG_BYTE_COUNT, 17'd20);
    add_byte(8'h22, "");
    add_cfg(REG_BYTE_COUNT, 17'd1);
    add_byte(8'h33, "");
    // Count of 65536, the full 16-bit address space, ended early
    add_cfg(REG_BYTE_COUNT, 17'h10000);
    add_cfg(REG_START_ADDRESS, 17'h08000);
    add_byte(8'h96, "");
    add_cfg(REG_BYTE_COUNT, 17'd2);
    add_byte(8'h69, "");

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    cfg_held = 1'b0;
    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        if (!cfg_held) quiesce();
        write_reg(stim_rows[r].idx, stim_rows[r].val);
        cfg_held = 1'b1;
      end else begin
        if (cfg_held) cfg_valid <= 1'b0;
        cfg_held = 1'b0;
        send_byte(stim_rows[r].val[7:0], stim_text[r], draw_gap());
      end
    end

    // Random phases: reconfigure while idle, then a batch of bytes
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_BYTES) begin
      quiesce();
      wrote = 1'b0;
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0:       new_count = '0;
          1:       new_count = 17'h10000;
          2:       new_count = COUNT_W'($urandom_range(1, 65536));
          default: new_count = COUNT_W'($urandom_range(1, 40));
        endcase
        write_reg(REG_BYTE_COUNT, new_count);
        wrote = 1'b1;
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_START_ADDRESS, COUNT_W'($urandom_range(0, 65535)));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                  COUNT_W'($urandom_range(0, 131071)));
        wrote = 1'b1;
      end
      if (wrote) cfg_valid <= 1'b0;

      // Mostly finish the open conversion, sometimes stop part way
      eff_count = (count_reg == '0) ? COUNT_W'(1) : count_reg;
      left      = (eff_count > img_pos) ? eff_count - img_pos : COUNT_W'(1);
      tx_burst  = ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) begin
        batch        = 40;
        tx_burst     = 1'b1;
        hold_off_req = 1'b1;
      end else if ($urandom_range(0, 9) < 6) begin
        batch = (left > 48) ? 48 : left;
      end else begin
        batch = $urandom_range(1, 20);
      end
      repeat (batch) send_byte(8'($urandom_range(0, 255)), "", draw_gap());
      random_sent += batch;
      phase++;
    end

    quiesce();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("intel_hex_record_encoder_unit_tb passed");
    end else begin
      $display("intel_hex_record_encoder_unit_tb failed");
    end
    $finish;
  end

endmodule
